// ----- src/efso_pkg.sv -----
package efso_pkg;

    localparam logic [0:0]  REG_SAMPLE_PERIOD   = 1'b0;
    localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd89478;
    localparam logic [31:0] Q30_ONE             = 32'h4000_0000;
    localparam logic [31:0] Q30_TWO             = 32'h8000_0000;

    // 2^(2^-i) in Q2.30, i = 1..12
    localparam logic [31:0] ROOT_Q30 [0:12] = '{
        32'd0,
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196444, 32'd1074468888, 32'd1074105294, 32'd1073923544
    };

    typedef struct packed {
        logic [14:0] frac;
        logic [5:0]  shift;
        logic        neg;
        logic [31:0] mag;
        logic        sync;
    } q_entry_t;

    // Node 2^(k / 2^bits) in Q2.30, evaluated at elaboration
    function automatic logic [31:0] exp_node(input int k, input int bits);
        logic [63:0] acc;
        int          i;
        acc = 64'(Q30_ONE);
        if (k >= (1 << bits))
        begin
            return Q30_TWO;
        end
        for (int j = 0; j < bits; j++)
        begin
            if (k[j])
            begin
                i   = bits - j;
                acc = (acc * 64'(ROOT_Q30[i]) + (64'd1 << 29)) >> 30;
            end
        end
        return acc[31:0];
    endfunction

endpackage

// ----- src/exp_fm_sawtooth_oscillator.sv -----
// Sawtooth oscillator, exponential pitch, hard sync.
// Input channel (in_valid/in_ready): one transaction per audio sample carrying
// pitch_control (Q1.15, full scale = OCTAVE_SPAN octaves), fundamental_hz (Q16.16)
// and sync_level (Q1.15, above zero clears the phase after the add).
// Output channel (out_valid/out_ready): one ramp_out transaction per input, Q1.15.
// APB port: register 0 at byte address 0 is sample_period (Q0.32 seconds).
// The back-end sequencer finishes one sample before it takes the next: it runs
// four products through the one shared 32x32 multiplier, then shift and commit.
// A two-entry queue sits between the front end and the sequencer, so inputs keep
// being taken while a sample is in flight.
// When the receiver stalls, the result holds in the output register; the
// sequencer waits at commit and the queue fills, after which in_ready drops.
// Reset clears phase to zero, empties the queue and loads sample_period with
// 1/48000.
module exp_fm_sawtooth_oscillator #(
    parameter int OCTAVE_SPAN    = 10,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pitch_control,
    input  logic signed [31:0] fundamental_hz,
    input  logic signed [15:0] sync_level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] ramp_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import efso_pkg::*;

    logic        sample_period_sel;
    logic [31:0] period_reg;
    logic [31:0] period_next;
    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    q_entry_t    entry;
    q_entry_t    q_head;

    assign pready = 1'b1;

    always_comb
    begin
        sample_period_sel = (paddr[2:2] == REG_SAMPLE_PERIOD);
        period_next       = period_reg;
        if (psel && penable && pwrite && sample_period_sel)
        begin
            period_next = pwdata;
        end
        prdata = sample_period_sel ? period_reg : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= SAMPLE_PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    efso_front #(
        .OCTAVE_SPAN(OCTAVE_SPAN)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pitch_control (pitch_control),
        .fundamental_hz(fundamental_hz),
        .sync_level    (sync_level),
        .q_full        (q_full),
        .push          (push),
        .entry         (entry)
    );

    efso_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(entry),
        .pop       (pop),
        .full      (q_full),
        .head_valid(q_valid),
        .head      (q_head)
    );

    efso_back #(
        .EXP_TABLE_BITS(EXP_TABLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .sample_period(period_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ramp_out     (ramp_out)
    );

endmodule

// ----- src/efso_front.sv -----
module efso_front #(
    parameter int OCTAVE_SPAN = 10
) (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pitch_control,
    input  logic signed [31:0] fundamental_hz,
    input  logic signed [15:0] sync_level,
    input  logic               q_full,
    output logic               push,
    output efso_pkg::q_entry_t entry
);
    import efso_pkg::*;

    localparam int         EU_W   = 15 + $clog2(2 * OCTAVE_SPAN);
    localparam logic [5:0] T_BASE = 6'(30 + OCTAVE_SPAN);

    logic [15:0]     pitch_off;
    logic [31:0]     eu_full;
    logic [EU_W-1:0] eu;
    logic [31:0]     freq_u;

    // offset exponent: OCTAVE_SPAN * (pitch + 1.0), always non-negative
    assign pitch_off = {~pitch_control[15], pitch_control[14:0]};
    assign eu_full   = 32'(OCTAVE_SPAN) * {16'b0, pitch_off};
    assign eu        = eu_full[EU_W-1:0];
    assign freq_u    = fundamental_hz;

    assign entry.frac  = eu[14:0];
    assign entry.shift = T_BASE - 6'(eu[EU_W-1:15]);
    assign entry.neg   = fundamental_hz[31];
    assign entry.mag   = fundamental_hz[31] ? (~freq_u + 32'd1) : freq_u;
    assign entry.sync  = !sync_level[15] && (sync_level[14:0] != 15'd0);

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

endmodule

// ----- src/efso_queue.sv -----
module efso_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  efso_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output efso_pkg::q_entry_t head
);
    import efso_pkg::*;

    q_entry_t   mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- src/efso_back.sv -----
module efso_back #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  efso_pkg::q_entry_t q_head,
    output logic               pop,
    input  logic [31:0]        sample_period,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] ramp_out
);
    import efso_pkg::*;

    localparam int          TB    = EXP_TABLE_BITS;
    localparam int          R     = 15 - TB;
    localparam int          NODES = (1 << TB) + 1;
    localparam int          NW    = TB + 1;
    localparam logic [63:0] HALF  = 64'd1 << (R - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BASE   = 3'd1;
    localparam logic [2:0] S_INTERP = 3'd2;
    localparam logic [2:0] S_MLO    = 3'd3;
    localparam logic [2:0] S_MHI    = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [31:0] node_tab [0:NODES-1];

    for (genvar g = 0; g < NODES; g++)
    begin : g_node
        assign node_tab[g] = exp_node(g, TB);
    end

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [14:0] frac_reg;
    logic [5:0]  shift_reg;
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic        sync_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [47:0] base_reg;
    logic [31:0] m_reg;
    logic [63:0] pl_reg;
    logic [47:0] ph_reg;
    logic [31:0] inc_reg;
    logic [31:0] phase_reg;
    logic [31:0] phase_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] ramp_reg;

    logic [NW-1:0] a_idx;
    logic [NW-1:0] b_idx;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   interp_sum;
    logic [79:0]   p_cat;
    logic [79:0]   p_shifted;
    logic [31:0]   inc_mag;
    logic          commit;

    assign a_idx = {1'b0, q_head.frac[14:R]};
    assign b_idx = a_idx + NW'(1);
    assign pop   = (state_reg == S_IDLE) && q_valid;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_BASE:
            begin
                mul_a = mag_reg;
                mul_b = sample_period;
            end
            S_INTERP:
            begin
                mul_a = b_reg - a_reg;
                mul_b = 32'(frac_reg[R-1:0]);
            end
            S_MLO:
            begin
                mul_a = m_reg;
                mul_b = base_reg[31:0];
            end
            S_MHI:
            begin
                mul_a = m_reg;
                mul_b = {16'b0, base_reg[47:32]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p      = {32'b0, mul_a} * {32'b0, mul_b};
    assign interp_sum = mul_p + HALF;
    assign p_cat      = {ph_reg, pl_reg[31:0]};
    assign p_shifted  = p_cat >> shift_reg;
    assign inc_mag    = p_shifted[31:0];
    assign commit     = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_BASE;
            S_BASE:   state_next = S_INTERP;
            S_INTERP: state_next = S_MLO;
            S_MLO:    state_next = S_MHI;
            S_MHI:    state_next = S_SHIFT;
            S_SHIFT:  state_next = S_COMMIT;
            S_COMMIT: if (commit) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase

        phase_next = phase_reg;
        if (commit)
        begin
            phase_next = sync_reg ? 32'd0 : phase_reg + inc_reg;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frac_reg  <= q_head.frac;
            shift_reg <= q_head.shift;
            neg_reg   <= q_head.neg;
            mag_reg   <= q_head.mag;
            sync_reg  <= q_head.sync;
            a_reg     <= node_tab[a_idx];
            b_reg     <= node_tab[b_idx];
        end
        if (state_reg == S_BASE)
        begin
            base_reg <= mul_p[63:16];
        end
        if (state_reg == S_INTERP)
        begin
            m_reg <= a_reg + 32'(interp_sum >> R);
        end
        if (state_reg == S_MLO)
        begin
            pl_reg <= mul_p;
        end
        if (state_reg == S_MHI)
        begin
            ph_reg <= mul_p[47:0] + {16'b0, pl_reg[63:32]};
        end
        if (state_reg == S_SHIFT)
        begin
            inc_reg <= neg_reg ? (32'd0 - inc_mag) : inc_mag;
        end
        if (commit)
        begin
            ramp_reg <= {~phase_next[31], phase_next[30:16]};
        end
    end

    assign out_valid = out_valid_reg;
    assign ramp_out  = ramp_reg;

endmodule
